@@ design/xfys_pkg.sv @@
// ----------------------------------------------------------------------------
// xfys_pkg
// types, constants and microcode table for the seeded card shuffler
// ----------------------------------------------------------------------------
package xfys_pkg;

  localparam int unsigned IDX_W = 6;   // card index / position width
  localparam int unsigned DIV_W = 7;   // divisor width, i+1 up to 64
  localparam int unsigned PC_W  = 4;   // microcode step counter width

  localparam logic [31:0] ZERO_SEED_SUBST = 32'h9E37_79B9;

  // datapath action of one control word
  typedef enum logic [3:0] {
    ACT_NOP        = 4'd0,
    ACT_ACCEPT     = 4'd1,
    ACT_FILL       = 4'd2,
    ACT_MOD_START  = 4'd3,
    ACT_READ       = 4'd4,
    ACT_WRITE_I    = 4'd5,
    ACT_WRITE_J    = 4'd6,
    ACT_EMIT_INIT  = 4'd7,
    ACT_EMIT_READ  = 4'd8,
    ACT_EMIT_LOAD  = 4'd9
  } act_e;

  // jump condition of one control word
  typedef enum logic [3:0] {
    COND_NONE      = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NO_INPUT  = 4'd2,
    COND_FILL_MORE = 4'd3,
    COND_I_ZERO    = 4'd4,
    COND_MOD_BUSY  = 4'd5,
    COND_I_MORE    = 4'd6,
    COND_OUT_FULL  = 4'd7,
    COND_EMIT_MORE = 4'd8
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic no_input;
    logic fill_more;
    logic i_zero;
    logic mod_busy;
    logic i_more;
    logic out_full;
    logic emit_more;
  } flags_t;

  // step labels
  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_FILL      = 4'd1;
  localparam logic [PC_W-1:0] PC_CHECK     = 4'd2;
  localparam logic [PC_W-1:0] PC_MOD_START = 4'd3;
  localparam logic [PC_W-1:0] PC_MOD_WAIT  = 4'd4;
  localparam logic [PC_W-1:0] PC_READ      = 4'd5;
  localparam logic [PC_W-1:0] PC_WRITE_I   = 4'd6;
  localparam logic [PC_W-1:0] PC_WRITE_J   = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT_INIT = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT_READ = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT_LOAD = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT_NEXT = 4'd11;
  localparam logic [PC_W-1:0] PC_DONE      = 4'd12;

  // microcode program
  function automatic cw_t rom_word(input logic [PC_W-1:0] pc);
    cw_t w;
    w = '{act: ACT_NOP, cond: COND_ALWAYS, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:      w = '{act: ACT_ACCEPT,    cond: COND_NO_INPUT,  target: PC_IDLE};
      PC_FILL:      w = '{act: ACT_FILL,      cond: COND_FILL_MORE, target: PC_FILL};
      PC_CHECK:     w = '{act: ACT_NOP,       cond: COND_I_ZERO,    target: PC_EMIT_INIT};
      PC_MOD_START: w = '{act: ACT_MOD_START, cond: COND_NONE,      target: PC_IDLE};
      PC_MOD_WAIT:  w = '{act: ACT_NOP,       cond: COND_MOD_BUSY,  target: PC_MOD_WAIT};
      PC_READ:      w = '{act: ACT_READ,      cond: COND_NONE,      target: PC_IDLE};
      PC_WRITE_I:   w = '{act: ACT_WRITE_I,   cond: COND_NONE,      target: PC_IDLE};
      PC_WRITE_J:   w = '{act: ACT_WRITE_J,   cond: COND_I_MORE,    target: PC_MOD_START};
      PC_EMIT_INIT: w = '{act: ACT_EMIT_INIT, cond: COND_NONE,      target: PC_IDLE};
      PC_EMIT_READ: w = '{act: ACT_EMIT_READ, cond: COND_NONE,      target: PC_IDLE};
      PC_EMIT_LOAD: w = '{act: ACT_EMIT_LOAD, cond: COND_OUT_FULL,  target: PC_EMIT_LOAD};
      PC_EMIT_NEXT: w = '{act: ACT_NOP,       cond: COND_EMIT_MORE, target: PC_EMIT_READ};
      PC_DONE:      w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: PC_IDLE};
      default:      w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/xorshift_fisher_yates_shuffle.sv @@
// ----------------------------------------------------------------------------
// xorshift_fisher_yates_shuffle
// seeded card shuffler: identity fill, xorshift32 fisher-yates, ordered dealout
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                payload
//   -------  ---  -----------------------  -------------------------------------
//   in       in   in_valid_i / in_stall_o  seed_i
//   out      out  out_valid_o / out_stall_i position_o card_index_o suit_o
//                                          rank_o last_o
//
// one seed transaction gives SUITS*RANKS output transactions
// steps per seed: accept, fill one entry per step, check, then per position
// from N-1 down to 1 a swap, then dealout init and read/load/next per card,
// and done; a swap is 1 start and a wait on the serial modulo + 3 store steps
// a deck store read port pair plus one write port limit a swap to three steps
// reset clears the step counter, divider and output valid; the deck store is
// reloaded at every seed so it needs no reset
// out_stall_i holds the dealout step; the last card may still wait in the
// output register while the next seed is taken
//
module xorshift_fisher_yates_shuffle #(
  parameter int unsigned SUITS = 4,
  parameter int unsigned RANKS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  position_o,
  output logic [5:0]  card_index_o,
  output logic [1:0]  suit_o,
  output logic [3:0]  rank_o,
  output logic        last_o
);
  import xfys_pkg::*;

  localparam int unsigned Deck   = SUITS * RANKS;
  localparam int unsigned AddrW  = (Deck > 1) ? $clog2(Deck) : 1;
  localparam logic [IDX_W-1:0] DeckLast = IDX_W'(Deck - 1);

  // sequencer
  cw_t    cw;
  flags_t flags;

  // datapath registers
  logic [31:0]      rng_q, rng_d;
  logic [IDX_W-1:0] i_q, i_d;        // fisher-yates position
  logic [IDX_W-1:0] j_q, j_d;        // swap partner
  logic [IDX_W-1:0] k_q, k_d;        // fill and dealout counter
  logic [31:0]      rng_next;

  // deck store
  logic [IDX_W-1:0] mem_q [Deck];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
  logic [IDX_W-1:0] rd_a_q, rd_b_q;

  // modulo unit
  logic             mod_busy;
  logic [IDX_W-1:0] mod_rem;
  logic             mod_start;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_full, out_load;
  logic [IDX_W-1:0] pos_q, card_q;
  logic [1:0]       suit_q;
  logic [3:0]       rank_q;
  logic             last_q;
  logic [1:0]       card_suit;
  logic [3:0]       card_rank;

  // suit is the count of suit boundaries at or below the card index
  function automatic logic [1:0] suit_of(input logic [IDX_W-1:0] c);
    logic [1:0] s;
    s = '0;
    for (int unsigned n = 1; n < SUITS; n++) begin
      if (c >= IDX_W'(n * RANKS)) begin
        s = s + 2'd1;
      end
    end
    return s;
  endfunction

  // xorshift32, shifts 13 / 17 / 5
  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  xfys_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  assign rng_next  = xs32(rng_q);
  assign mod_start = (cw.act == ACT_MOD_START);

  xfys_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rng_next),
    .divisor_i  ({1'b0, i_q} + DIV_W'(1)),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  assign in_stall_o = (cw.act != ACT_ACCEPT);
  assign out_full   = out_valid_q && out_stall_i;
  assign out_load   = (cw.act == ACT_EMIT_LOAD) && !out_full;

  assign flags = '{
    no_input:  !in_valid_i,
    fill_more: (k_q != DeckLast),
    i_zero:    (i_q == '0),
    mod_busy:  mod_busy,
    i_more:    (i_q != IDX_W'(1)),
    out_full:  out_full,
    emit_more: !last_q
  };

  // datapath control
  always_comb begin
    rng_d     = rng_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    wr_en     = 1'b0;
    wr_addr   = k_q;
    wr_data   = k_q;
    rd_en     = 1'b0;
    rd_addr_a = i_q;
    rd_addr_b = mod_rem;
    unique case (cw.act)
      ACT_ACCEPT: begin
        if (in_valid_i) begin
          rng_d = (seed_i == '0) ? ZERO_SEED_SUBST : seed_i;
          i_d   = DeckLast;
          k_d   = '0;
        end
      end
      ACT_FILL: begin
        // identity ordering, one entry per step
        wr_en = 1'b1;
        k_d   = k_q + IDX_W'(1);
      end
      ACT_MOD_START: begin
        rng_d = rng_next;
      end
      ACT_READ: begin
        rd_en = 1'b1;
        j_d   = mod_rem;
      end
      ACT_WRITE_I: begin
        wr_en   = 1'b1;
        wr_addr = i_q;
        wr_data = rd_b_q;
      end
      ACT_WRITE_J: begin
        wr_en   = 1'b1;
        wr_addr = j_q;
        wr_data = rd_a_q;
        i_d     = i_q - IDX_W'(1);
      end
      ACT_EMIT_INIT: begin
        k_d = '0;
      end
      ACT_EMIT_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = k_q;
      end
      ACT_EMIT_LOAD: begin
        if (!out_full) begin
          k_d = k_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rng_q <= rng_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
  end

  // deck store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a[AddrW-1:0]];
      rd_b_q <= mem_q[rd_addr_b[AddrW-1:0]];
    end
  end

  // card split into suit and rank
  assign card_suit = suit_of(rd_a_q);
  assign card_rank = 4'(rd_a_q - IDX_W'(card_suit * RANKS));

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q  <= k_q;
      card_q <= rd_a_q;
      suit_q <= card_suit;
      rank_q <= card_rank;
      last_q <= (k_q == DeckLast);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = pos_q;
  assign card_index_o = card_q;
  assign suit_o       = suit_q;
  assign rank_o       = rank_q;
  assign last_o       = last_q;

endmodule

@@ design/xfys_mod.sv @@
// ----------------------------------------------------------------------------
// xfys_mod
// bit-serial restoring modulo, 32-bit dividend by a 7-bit divisor
// ----------------------------------------------------------------------------
module xfys_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                dividend_i,
  input  logic [xfys_pkg::DIV_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [xfys_pkg::IDX_W-1:0] rem_o
);
  import xfys_pkg::*;

  logic             busy_q, busy_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [31:0]      num_q, num_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // one quotient bit per cycle, remainder stays below the divisor
      if (trial >= den_q) begin
        rem_d = IDX_W'(trial - den_q);
      end else begin
        rem_d = IDX_W'(trial);
      end
      num_d = {num_q[30:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

@@ design/xfys_seq.sv @@
// ----------------------------------------------------------------------------
// xfys_seq
// step counter and microcode table with conditional jumps
// ----------------------------------------------------------------------------
module xfys_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xfys_pkg::flags_t flags_i,
  output xfys_pkg::cw_t    cw_o
);
  import xfys_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  cw_t             cw;
  logic            take;

  assign cw = rom_word(pc_q);

  always_comb begin
    unique case (cw.cond)
      COND_NONE:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = flags_i.no_input;
      COND_FILL_MORE: take = flags_i.fill_more;
      COND_I_ZERO:    take = flags_i.i_zero;
      COND_MOD_BUSY:  take = flags_i.mod_busy;
      COND_I_MORE:    take = flags_i.i_more;
      COND_OUT_FULL:  take = flags_i.out_full;
      COND_EMIT_MORE: take = flags_i.emit_more;
      default:        take = 1'b1;
    endcase
    pc_d = take ? cw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign cw_o = cw;

endmodule
